>>> sv/rn_pkg.sv
// Shared types and constants for the rational normalizer.
// Holds the transaction payload structs and the controller/datapath command and status.
// No dependencies.
`default_nettype none

package rn_pkg;

  // Width of numerator, denominator and the reduced values
  localparam int unsigned DATA_WIDTH = 32;
  // Width of the trailing-zero count and of the division bit counter
  localparam int unsigned ShiftWidth = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator;
    logic signed [DATA_WIDTH-1:0] denominator;
  } rn_in_t;

  typedef struct packed {
    logic                         is_whole;
    logic signed [DATA_WIDTH-1:0] value_num;
    logic signed [DATA_WIDTH-1:0] value_den;
    logic                         div_zero;
  } rn_out_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic emit;
  } rn_cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_last;
  } rn_status_t;

endpackage

`default_nettype wire

>>> sv/rational_normalizer.sv
// Rational normalizer: reduces a signed fraction to lowest terms by a binary gcd.
// After accept it runs the gcd steps, then the division, then moves the result into the
// output register; zero operands skip the gcd and the division.
// Transactions are handled one at a time, the next taken in the cycle after the result enters
// the output register; a stalled output register holds the block longer.
// Reset: rst_ni async active low; clears controller state and the output valid.
`default_nettype none

module rational_normalizer import rn_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire rn_in_t  in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output rn_out_t      out_data_o
);

  // Commands from the controller, status back from the datapath
  rn_cmd_t    cmd;
  rn_status_t status;

  // Controller: accept only when idle, hold the result in the output register
  // while the downstream side stalls, and let the next transaction start as
  // soon as the current one has moved into that register.
  rn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: magnitudes, gcd by halving and odd-odd subtraction, then the two
  // quotients by restoring division, then sign restore and saturation.
  rn_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  // A zero-denominator result carries nothing but the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.div_zero) |->
      (!out_data_o.is_whole && out_data_o.value_num == '0 && out_data_o.value_den == '0))
    else $error("div_zero result with non-zero fields");

  // A whole-number result always has unit denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_whole) |-> (out_data_o.value_den == DATA_WIDTH'(1)))
    else $error("integer result without unit denominator");

  // A fraction result never has a denominator of zero or plus/minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.is_whole && !out_data_o.div_zero) |->
      (out_data_o.value_den != '0 && out_data_o.value_den != DATA_WIDTH'(1)
       && out_data_o.value_den != '1))
    else $error("fraction result with degenerate denominator");

  // Once a transaction is taken, input stays stalled while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

endmodule

`default_nettype wire

>>> sv/rn_datapath.sv
// Datapath of the rational normalizer: binary gcd unit, two restoring dividers
// sharing the gcd as divisor, result formatting and the output data register.
// Depends on rn_pkg.
`default_nettype none

module rn_datapath import rn_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rn_cmd_t    cmd_i,
  input  wire rn_in_t     in_data_i,
  output rn_status_t      status_o,
  output rn_out_t         out_data_o
);

  localparam int unsigned W = DATA_WIDTH;
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] One = W'(1);

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + One) : v;
  endfunction

  logic                  num_neg_q, den_neg_q, num_zero_q, den_zero_q;
  logic [W-1:0]          an_q, ad_q;
  logic [W-1:0]          a_q, a_d, b_q, b_d;
  logic [ShiftWidth-1:0] k_q, k_d;
  logic [W-1:0]          g_q;
  logic [W-1:0]          qn_q, qd_q, rn_q, rd_q;
  logic [ShiftWidth-1:0] cnt_q;
  rn_out_t               out_q, res;

  logic [W-1:0] num_raw, den_raw, an_in, ad_in;
  logic         a_ge_b;
  logic [W-1:0] sub_ab;

  logic [W:0]   rem_n, rem_d, gx, diff_n, diff_d;
  logic         ge_n, ge_d;
  logic [W-1:0] qn_mag_neg, qd_mag_neg;

  assign num_raw = in_data_i.numerator;
  assign den_raw = in_data_i.denominator;
  assign an_in   = mag(num_raw);
  assign ad_in   = mag(den_raw);

  // One binary gcd step: strip common twos, strip single twos, or subtract odd from odd
  assign a_ge_b = a_q >= b_q;
  assign sub_ab = a_ge_b ? (a_q - b_q) : (b_q - a_q);

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (!a_q[0] && !b_q[0]) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + ShiftWidth'(1);
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_ge_b) begin
      a_d = sub_ab >> 1;
    end else begin
      b_d = sub_ab >> 1;
    end
  end

  // Restoring division, one quotient bit per cycle for each of the two dividends
  assign gx     = {1'b0, g_q};
  assign rem_n  = {rn_q, qn_q[W-1]};
  assign rem_d  = {rd_q, qd_q[W-1]};
  assign ge_n   = rem_n >= gx;
  assign ge_d   = rem_d >= gx;
  assign diff_n = rem_n - gx;
  assign diff_d = rem_d - gx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_neg_q  <= 1'b0;
      den_neg_q  <= 1'b0;
      num_zero_q <= 1'b0;
      den_zero_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        num_neg_q  <= num_raw[W-1];
        den_neg_q  <= den_raw[W-1];
        num_zero_q <= num_raw == '0;
        den_zero_q <= den_raw == '0;
      end
      if (cmd_i.div_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + ShiftWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      an_q <= an_in;
      ad_q <= ad_in;
      a_q  <= an_in;
      b_q  <= ad_in;
      k_q  <= '0;
    end else if (cmd_i.gcd_step) begin
      a_q <= a_d;
      b_q <= b_d;
      k_q <= k_d;
    end
    if (cmd_i.div_init) begin
      g_q  <= (a_q | b_q) << k_q;
      qn_q <= an_q;
      qd_q <= ad_q;
      rn_q <= '0;
      rd_q <= '0;
    end else if (cmd_i.div_step) begin
      rn_q <= ge_n ? diff_n[W-1:0] : rem_n[W-1:0];
      rd_q <= ge_d ? diff_d[W-1:0] : rem_d[W-1:0];
      qn_q <= {qn_q[W-2:0], ge_n};
      qd_q <= {qd_q[W-2:0], ge_d};
    end
    if (cmd_i.emit) begin
      out_q <= res;
    end
  end

  assign qn_mag_neg = ~qn_q + One;
  assign qd_mag_neg = ~qd_q + One;

  // Sign and saturate the reduced magnitudes
  always_comb begin
    res = '0;
    if (den_zero_q) begin
      res.div_zero = 1'b1;
    end else if (num_zero_q) begin
      res.is_whole  = 1'b1;
      res.value_den = One;
    end else if (qd_q == One) begin
      res.is_whole  = 1'b1;
      res.value_den = One;
      if (num_neg_q != den_neg_q) begin
        res.value_num = qn_mag_neg;
      end else begin
        res.value_num = (qn_q > MaxPos) ? MaxPos : qn_q;
      end
    end else begin
      res.value_num = num_neg_q ? qn_mag_neg : qn_q;
      res.value_den = den_neg_q ? qd_mag_neg : qd_q;
    end
  end

  assign status_o.special  = num_zero_q || den_zero_q;
  assign status_o.gcd_done = (a_q == '0) || (b_q == '0);
  assign status_o.div_last = cnt_q == ShiftWidth'(W - 1);
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

>>> sv/rn_ctrl.sv
// Controller of the rational normalizer: sequences load, gcd, division and
// result hand-off, and owns the output valid flag. Depends on rn_pkg.
`default_nettype none

module rn_ctrl import rn_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire rn_status_t  status_i,
  output rn_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StGcd,
    StDiv,
    StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StGcd;
        end
      end
      StGcd: begin
        if (status_i.special) begin
          state_d = StDone;
        end else if (status_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
